[design/mgct_pkg.sv]
// ----------------------------------------------------------------------------
// mgct_pkg
// Shared constants and types for the max gap cut tracker.
// ----------------------------------------------------------------------------
package mgct_pkg;

  localparam int unsigned MaxLenDefault = 4096;
  localparam int unsigned CfgW          = 13;
  localparam int unsigned PosW          = 12;
  localparam int unsigned AreaW         = 25;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  localparam logic OpHoriz = 1'b0;
  localparam logic OpVert  = 1'b1;

endpackage

[design/mgct_ram.sv]
// ----------------------------------------------------------------------------
// mgct_ram
// Generic single-port synchronous RAM, one write or read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module mgct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/max_gap_cut_tracker.sv]
// ----------------------------------------------------------------------------
// max_gap_cut_tracker
// Tracks cuts on both axes of a sheet and reports the largest piece area.
//
// channel   dir  handshake                  payload
// s_axis    in   s_tvalid_i / s_tready_o    tdata: cut_position[11:0]; tuser: operation
// m_axis    out  m_tvalid_o / m_tready_i    tdata: largest_area[24:0]; tuser: rejected
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A rejected cut goes straight to its result; an accepted cut first runs the
// neighbor scans, the piece-count updates and the longest-piece search, which
// read one RAM entry at a time.
// Reset and each config write start a clearing pass over all 2**(LenW+1) RAM
// entries (16384 by default) and two init writes; no beat is taken then.
// A result waits in the output register; the next cut is taken meanwhile and
// holds before loading its own result until the waiting beat goes.
// ----------------------------------------------------------------------------
module max_gap_cut_tracker
  import mgct_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [15:0]      s_tdata_i,  // cut_position[11:0]
  input  logic [0:0]       s_tuser_i,  // operation
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [31:0]      m_tdata_o,  // largest_area[24:0]
  output logic [0:0]       m_tuser_o,  // rejected
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int unsigned LenW = ($clog2(MaxLen + 1) > PosW + 1) ?
                                 $clog2(MaxLen + 1) : PosW + 1;
  localparam int unsigned AddrW = LenW + 1;
  localparam int unsigned Depth = 2 * (1 << LenW);
  localparam int unsigned MapW = 1;
  localparam int unsigned CntW = LenW;
  localparam int unsigned EntW = MapW + CntW;
  localparam int unsigned Prod = (LenW * 2 > AreaW) ? LenW * 2 : AreaW;

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE, S_CHK_RD, S_CHK, S_LO_RD, S_LO, S_HI_RD, S_HI,
    S_DEC_RD, S_DEC_WR, S_A_RD, S_A_WR, S_B_RD, S_B_WR, S_SET_RD, S_SET_WR,
    S_LONG_RD, S_LONG_CHK, S_MUL
  } state_e;

  state_e          state_q;
  logic [AddrW-1:0] addr;
  logic            we;
  logic [EntW-1:0] wdata, rdata;
  logic [LenW-1:0] wlen_q, hlen_q, wlong_q, hlong_q;
  logic [LenW-1:0] x_q, lo_q, hi_q, ptr_q;
  logic            ax_q, rej_q, mv_q, rej_out_q;
  logic [AddrW-1:0] clr_q;
  logic [1:0]      init_q;
  logic [AreaW-1:0] area_q;
  logic [Prod-1:0] prod;
  logic [LenW-1:0] len, longv, clamped;
  logic [Prod-1:0] wl_x, hl_x;

  // entry: {cut bit, piece count}; address {axis, position/length}
  mgct_ram #(.Width(EntW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign len   = ax_q ? wlen_q : hlen_q;
  assign longv = ax_q ? wlong_q : hlong_q;
  assign wl_x  = Prod'(wlong_q);
  assign hl_x  = Prod'(hlong_q);
  assign prod  = wl_x * hl_x;

  always_comb begin
    logic [CfgW-1:0] v;
    v = cfg_data_i[CfgW-1:0];
    if (v < CfgW'(2)) clamped = LenW'(2);
    else if ({19'b0, v} > 32'(MaxLen)) clamped = LenW'(MaxLen);
    else clamped = LenW'(v);
  end

  always_comb begin
    we = 1'b0;
    addr = {ax_q, ptr_q};
    wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        addr = clr_q;
      end
      S_INIT: begin
        we = 1'b1;
        addr = init_q[0] ? {1'b1, wlen_q} : {1'b0, hlen_q};
        wdata = {1'b0, CntW'(1)};
      end
      S_DEC_WR: begin
        we = 1'b1;
        wdata = {rdata[EntW-1],
                 (rdata[CntW-1:0] != '0) ? rdata[CntW-1:0] - CntW'(1) : CntW'(0)};
      end
      S_A_WR, S_B_WR: begin
        we = 1'b1;
        wdata = {rdata[EntW-1], rdata[CntW-1:0] + CntW'(1)};
      end
      S_SET_WR: begin
        we = 1'b1;
        wdata = {1'b1, rdata[CntW-1:0]};
      end
      default: ;
    endcase
  end

  assign s_tready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = mv_q;
  assign m_tdata_o   = 32'(area_q);
  assign m_tuser_o   = rej_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      init_q <= '0;
      wlen_q <= LenW'(MaxLen);
      hlen_q <= LenW'(MaxLen);
      wlong_q <= LenW'(MaxLen);
      hlong_q <= LenW'(MaxLen);
      mv_q <= 1'b0;
      ax_q <= 1'b0;
      x_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      ptr_q <= '0;
      rej_q <= 1'b0;
      rej_out_q <= 1'b0;
      area_q <= '0;
    end else begin
      if (mv_q && m_tready_i) mv_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgIdxWidth) wlen_q <= clamped;
        else hlen_q <= clamped;
        state_q <= S_CLEAR;
        clr_q <= '0;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + AddrW'(1);
            if (clr_q == AddrW'(Depth - 1)) begin
              state_q <= S_INIT;
              init_q <= '0;
            end
          end
          S_INIT: begin
            init_q <= init_q + 2'd1;
            if (init_q[0]) begin
              wlong_q <= wlen_q;
              hlong_q <= hlen_q;
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_tvalid_i) begin
              ax_q <= (s_tuser_i[0] == OpVert);
              x_q <= LenW'(s_tdata_i[PosW-1:0]);
              ptr_q <= LenW'(s_tdata_i[PosW-1:0]);
              state_q <= S_CHK_RD;
            end
          end
          S_CHK_RD: state_q <= S_CHK;
          S_CHK: begin
            if (x_q == '0 || x_q >= len || rdata[EntW-1]) begin
              rej_q <= 1'b1;
              state_q <= S_MUL;
            end else begin
              rej_q <= 1'b0;
              ptr_q <= x_q - LenW'(1);
              state_q <= S_LO_RD;
            end
          end
          S_LO_RD: begin
            if (ptr_q == '0) begin
              lo_q <= ptr_q;
              ptr_q <= x_q + LenW'(1);
              state_q <= S_HI_RD;
            end else state_q <= S_LO;
          end
          S_LO: begin
            if (rdata[EntW-1]) begin
              lo_q <= ptr_q;
              ptr_q <= x_q + LenW'(1);
              state_q <= S_HI_RD;
            end else begin
              ptr_q <= ptr_q - LenW'(1);
              state_q <= S_LO_RD;
            end
          end
          S_HI_RD: begin
            if (ptr_q >= len) begin
              hi_q <= ptr_q;
              ptr_q <= ptr_q - lo_q;
              state_q <= S_DEC_RD;
            end else state_q <= S_HI;
          end
          S_HI: begin
            if (rdata[EntW-1]) begin
              hi_q <= ptr_q;
              ptr_q <= ptr_q - lo_q;
              state_q <= S_DEC_RD;
            end else begin
              ptr_q <= ptr_q + LenW'(1);
              state_q <= S_HI_RD;
            end
          end
          S_DEC_RD: state_q <= S_DEC_WR;
          S_DEC_WR: begin
            ptr_q <= x_q - lo_q;
            state_q <= S_A_RD;
          end
          S_A_RD: state_q <= S_A_WR;
          S_A_WR: begin
            ptr_q <= hi_q - x_q;
            state_q <= S_B_RD;
          end
          S_B_RD: state_q <= S_B_WR;
          S_B_WR: begin
            ptr_q <= x_q;
            state_q <= S_SET_RD;
          end
          S_SET_RD: state_q <= S_SET_WR;
          S_SET_WR: begin
            ptr_q <= longv;
            state_q <= S_LONG_RD;
          end
          S_LONG_RD: state_q <= S_LONG_CHK;
          S_LONG_CHK: begin
            if (longv > LenW'(1) && rdata[CntW-1:0] == '0) begin
              if (ax_q) wlong_q <= wlong_q - LenW'(1);
              else hlong_q <= hlong_q - LenW'(1);
              ptr_q <= longv - LenW'(1);
              state_q <= S_LONG_RD;
            end else state_q <= S_MUL;
          end
          S_MUL: begin
            if (!mv_q) begin
              area_q <= prod[AreaW-1:0];
              rej_out_q <= rej_q;
              mv_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o));

  a_in_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> state_q == S_CHK_RD);

  a_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> wlong_q <= wlen_q && hlong_q <= hlen_q &&
                          wlong_q != '0 && hlong_q != '0);

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tdata_o[31:AreaW] == '0);

endmodule
